// ----- sv/barrett_modular_multiplier_assert.svh -----
// Assertion macros shared by the Barrett multiplier checker.
`ifndef BARRETT_MODULAR_MULTIPLIER_ASSERT_SVH
`define BARRETT_MODULAR_MULTIPLIER_ASSERT_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define BMM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define BMM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/bmm_pkg.sv -----
// Types, register indexes and constants of the Barrett modular multiplier.
package bmm_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned BITS_W      = 6;

   typedef logic [31:0]  half_type;
   typedef logic [63:0]  word_type;
   typedef logic [127:0] dword_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODULUS        = 2'd0,
      CSR_MODULUS_BITS   = 2'd1,
      CSR_BARRETT_FACTOR = 2'd2
   } csr_index_type;

   localparam logic [BITS_W-1:0] MODULUS_BITS_RESET   = 6'd2;
   localparam word_type          BARRETT_FACTOR_RESET = 64'd42;
   localparam int unsigned       MODULUS_RESET        = 3;

   // smallest usable bit length, also the offset of the first shift
   localparam logic [BITS_W-1:0] BITS_MIN       = 6'd2;
   // extra right shift applied to the scaled product
   localparam logic [BITS_W:0]   Q_SHIFT_OFFSET = 7'd5;
   // conditional subtractions after the estimate
   localparam int unsigned       NUM_CORR       = 3;

   // nine arithmetic stages plus one per correction step
   localparam int unsigned       PIPE_DEPTH     = 9 + NUM_CORR;

   // exact 32x32 unsigned product
   function automatic word_type mul32(half_type x, half_type y);
      mul32 = {32'b0, x} * {32'b0, y};
   endfunction

endpackage

// ----- sv/barrett_modular_multiplier.sv -----
// Pipelined Barrett modular multiplier, residue = multiplicand * multiplier mod modulus.
// Stages: 9 arithmetic + 3 correction from request accept to residue valid.
// Throughput: one request per cycle unless rsp_stall backs up a full pipe; each stage holds
// one request, bubbles collapse under stall; one bank of 32x32 partial products per product.
// Reset (synchronous) clears all stage valid bits and loads modulus 3, bit length 2,
// factor 42; configuration writes take effect on the next edge.
module barrett_modular_multiplier #(
   parameter int unsigned MOD_WIDTH = 59
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [MOD_WIDTH-1:0]               req_multiplicand,
   input  logic [MOD_WIDTH-1:0]               req_multiplier,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [MOD_WIDTH-1:0]               rsp_residue,
   input  logic                               csr_wen,
   input  logic [bmm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bmm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import bmm_pkg::*;

   localparam int unsigned PROD_W = 2 * MOD_WIDTH;
   localparam int unsigned PAD_W  = 64 - MOD_WIDTH;
   localparam logic [BITS_W-1:0] BITS_MAX = BITS_W'(MOD_WIDTH);

   localparam int unsigned S_PP1  = 0;
   localparam int unsigned S_PROD = 1;
   localparam int unsigned S_T    = 2;
   localparam int unsigned S_PP2  = 3;
   localparam int unsigned S_SUM  = 4;
   localparam int unsigned S_TF   = 5;
   localparam int unsigned S_Q    = 6;
   localparam int unsigned S_QM   = 7;
   localparam int unsigned S_REM  = 8;
   localparam int unsigned S_CORR = 9;

   // configuration registers
   logic [MOD_WIDTH-1:0] modulus_ff;
   logic [BITS_W-1:0]    modulus_bits_ff;
   word_type             barrett_factor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff        <= MOD_WIDTH'(MODULUS_RESET);
         modulus_bits_ff   <= MODULUS_BITS_RESET;
         barrett_factor_ff <= BARRETT_FACTOR_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_MODULUS:        modulus_ff        <= csr_wdata[MOD_WIDTH-1:0];
            CSR_MODULUS_BITS:   modulus_bits_ff   <= csr_wdata[BITS_W-1:0];
            CSR_BARRETT_FACTOR: barrett_factor_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp bit length and derive both shift amounts
   logic [BITS_W-1:0] bits_eff;
   logic [BITS_W-1:0] shift_t;
   logic [BITS_W:0]   shift_q;
   word_type          mod64;

   always_comb begin
      if (modulus_bits_ff < BITS_MIN) begin
         bits_eff = BITS_MIN;
      end else if (modulus_bits_ff > BITS_MAX) begin
         bits_eff = BITS_MAX;
      end else begin
         bits_eff = modulus_bits_ff;
      end
      shift_t = bits_eff - BITS_MIN;
      shift_q = {1'b0, bits_eff} + Q_SHIFT_OFFSET;
      mod64   = word_type'(modulus_ff);
   end

   // stage valid bits and per-stage ready
   logic [PIPE_DEPTH-1:0] valid_ff;
   logic [PIPE_DEPTH-1:0] ready;

   always_comb begin
      ready[PIPE_DEPTH-1] = !valid_ff[PIPE_DEPTH-1] || !rsp_stall;
      for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < PIPE_DEPTH; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[PIPE_DEPTH-1];

   // payload registers
   word_type          ll_ff, lh_ff, hl_ff, hh_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] t_ff;
   word_type          plo_ff [S_T:S_QM];
   word_type          p00_ff, p01_ff, p10_ff, p11_ff, p20_ff, p21_ff, p30_ff;
   dword_type         sum_a_ff, sum_b_ff;
   dword_type         tf_ff;
   word_type          q_ff;
   word_type          c0_ff;
   half_type          c1_ff, c2_ff;
   word_type          rem_ff;
   word_type          corr_ff [NUM_CORR];

   // next values
   word_type  a64, b64;
   logic [64:0] mid;
   dword_type prod_full;
   dword_type t128;
   half_type  t0, t1, t2, t3, f0, f1;
   logic [64:0] m1;
   word_type  m3;
   dword_type sum_a_in, sum_b_in;
   dword_type tq;
   word_type  c1_full, c2_full;
   word_type  qm_low;
   word_type  rem_in;
   word_type  corr_in [NUM_CORR];

   always_comb begin
      a64       = {{PAD_W{1'b0}}, req_multiplicand};
      b64       = {{PAD_W{1'b0}}, req_multiplier};

      mid       = {1'b0, lh_ff} + {1'b0, hl_ff};
      prod_full = {hh_ff, ll_ff} + dword_type'({mid, 32'b0});

      t128      = dword_type'(t_ff);
      t0        = t128[31:0];
      t1        = t128[63:32];
      t2        = t128[95:64];
      t3        = t128[127:96];
      f0        = barrett_factor_ff[31:0];
      f1        = barrett_factor_ff[63:32];

      // terms at bit 96 keep only their low 32 bits under the 128-bit wrap
      m1        = {1'b0, p01_ff} + {1'b0, p10_ff};
      m3        = p21_ff + p30_ff;
      sum_a_in  = {p11_ff, p00_ff} + {p20_ff, 64'b0};
      sum_b_in  = dword_type'({m1, 32'b0}) + {m3[31:0], 96'b0};

      tq        = tf_ff >> shift_q;

      c1_full   = mul32(q_ff[31:0], mod64[63:32]);
      c2_full   = mul32(q_ff[63:32], mod64[31:0]);

      qm_low    = c0_ff + {c1_ff + c2_ff, 32'b0};
      rem_in    = plo_ff[S_QM] - qm_low;

      for (int i = 0; i < NUM_CORR; i++) begin
         if (i == 0) begin
            corr_in[i] = (rem_ff >= mod64) ? rem_ff - mod64 : rem_ff;
         end else begin
            corr_in[i] = (corr_ff[i-1] >= mod64) ? corr_ff[i-1] - mod64 : corr_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[S_PP1]) begin
         ll_ff <= mul32(a64[31:0],  b64[31:0]);
         lh_ff <= mul32(a64[31:0],  b64[63:32]);
         hl_ff <= mul32(a64[63:32], b64[31:0]);
         hh_ff <= mul32(a64[63:32], b64[63:32]);
      end
      if (ready[S_PROD]) begin
         prod_ff <= prod_full[PROD_W-1:0];
      end
      if (ready[S_T]) begin
         t_ff          <= prod_ff >> shift_t;
         plo_ff[S_T]   <= word_type'(prod_ff);
      end
      if (ready[S_PP2]) begin
         p00_ff        <= mul32(t0, f0);
         p01_ff        <= mul32(t0, f1);
         p10_ff        <= mul32(t1, f0);
         p11_ff        <= mul32(t1, f1);
         p20_ff        <= mul32(t2, f0);
         p21_ff        <= mul32(t2, f1);
         p30_ff        <= mul32(t3, f0);
         plo_ff[S_PP2] <= plo_ff[S_T];
      end
      if (ready[S_SUM]) begin
         sum_a_ff      <= sum_a_in;
         sum_b_ff      <= sum_b_in;
         plo_ff[S_SUM] <= plo_ff[S_PP2];
      end
      if (ready[S_TF]) begin
         tf_ff         <= sum_a_ff + sum_b_ff;
         plo_ff[S_TF]  <= plo_ff[S_SUM];
      end
      if (ready[S_Q]) begin
         q_ff          <= tq[63:0];
         plo_ff[S_Q]   <= plo_ff[S_TF];
      end
      if (ready[S_QM]) begin
         c0_ff         <= mul32(q_ff[31:0], mod64[31:0]);
         c1_ff         <= c1_full[31:0];
         c2_ff         <= c2_full[31:0];
         plo_ff[S_QM]  <= plo_ff[S_Q];
      end
      if (ready[S_REM]) begin
         rem_ff <= rem_in;
      end
      for (int i = 0; i < NUM_CORR; i++) begin
         if (ready[S_CORR+i]) begin
            corr_ff[i] <= corr_in[i];
         end
      end
   end

   assign rsp_residue = corr_ff[NUM_CORR-1][MOD_WIDTH-1:0];

endmodule

// ----- sv/bmm_checker.sv -----
// Port-level checker for the Barrett modular multiplier and its bind.
`include "barrett_modular_multiplier_assert.svh"

module bmm_checker #(
   parameter int unsigned MOD_WIDTH = 59
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [MOD_WIDTH-1:0] rsp_residue
);
   import bmm_pkg::*;

   localparam int unsigned CNT_W = $clog2(PIPE_DEPTH + 1);

   logic             req_acc, rsp_acc;
   logic [CNT_W-1:0] inflight_ff, inflight_in;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   // track requests accepted but not yet delivered
   always_comb begin
      inflight_in = inflight_ff;
      if (req_acc && !rsp_acc) begin
         inflight_in = inflight_ff + CNT_W'(1);
      end else if (!req_acc && rsp_acc) begin
         inflight_in = inflight_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   `BMM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_residue), "stalled response changed")
   `BMM_ASSERT_NOW(a_flow_through, !rsp_stall, !req_stall, "request stalled while output drains")
   `BMM_ASSERT_NOW(a_no_phantom, inflight_ff == '0, !rsp_valid, "response without a request")
   `BMM_ASSERT_NOW(a_depth, 1'b1, inflight_ff <= CNT_W'(PIPE_DEPTH), "more requests in flight than stages")

endmodule

bind barrett_modular_multiplier bmm_checker #(.MOD_WIDTH(MOD_WIDTH)) u_bmm_checker (.*);
